// ===== rtl/core/cltc_pkg.sv =====
// Shared types, constants and keyword tables of the token classifier.
package cltc_pkg;

	localparam int NUM_KW          = 31;
	localparam int DEF_MAX_KW_LEN  = 8;
	localparam int DEF_QUEUE_DEPTH = 4;
	localparam int CLASS_W         = 6;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_SQUOTE = 8'd39;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_DOLLAR = 8'h24;

	localparam logic [CLASS_W-1:0] CL_IDENT  = 6'd0;
	localparam logic [CLASS_W-1:0] CL_INT    = 6'd1;
	localparam logic [CLASS_W-1:0] CL_REAL   = 6'd2;
	localparam logic [CLASS_W-1:0] CL_STRING = 6'd3;
	localparam logic [CLASS_W-1:0] CL_ADD    = 6'd5;
	localparam logic [CLASS_W-1:0] CL_MUL    = 6'd6;
	localparam logic [CLASS_W-1:0] CL_REL    = 6'd7;
	localparam logic [CLASS_W-1:0] CL_OR     = 6'd8;
	localparam logic [CLASS_W-1:0] CL_AND    = 6'd9;
	localparam logic [CLASS_W-1:0] CL_NOT    = 6'd10;
	localparam logic [CLASS_W-1:0] CL_EQNE   = 6'd11;
	localparam logic [CLASS_W-1:0] CL_SEMI   = 6'd12;
	localparam logic [CLASS_W-1:0] CL_SQUOTE = 6'd13;
	localparam logic [CLASS_W-1:0] CL_LPAREN = 6'd14;
	localparam logic [CLASS_W-1:0] CL_RPAREN = 6'd15;
	localparam logic [CLASS_W-1:0] CL_LBRACE = 6'd16;
	localparam logic [CLASS_W-1:0] CL_RBRACE = 6'd17;
	localparam logic [CLASS_W-1:0] CL_ASSIGN = 6'd18;
	localparam logic [CLASS_W-1:0] CL_DOLLAR = 6'd23;

	typedef enum logic [27:0] {
		S_START     = 28'd1 << 0,
		S_IDENT     = 28'd1 << 1,
		S_INT       = 28'd1 << 2,
		S_DOT       = 28'd1 << 3,
		S_REAL      = 28'd1 << 4,
		S_STR_OPEN  = 28'd1 << 5,
		S_STR_EMPTY = 28'd1 << 6,
		S_STR_BODY  = 28'd1 << 7,
		S_STR_DONE  = 28'd1 << 8,
		S_ADD       = 28'd1 << 9,
		S_MUL       = 28'd1 << 10,
		S_REL       = 28'd1 << 11,
		S_REL_EQ    = 28'd1 << 12,
		S_BAR       = 28'd1 << 13,
		S_OR        = 28'd1 << 14,
		S_AMP       = 28'd1 << 15,
		S_AND       = 28'd1 << 16,
		S_NOT       = 28'd1 << 17,
		S_NE        = 28'd1 << 18,
		S_ASSIGN    = 28'd1 << 19,
		S_EQ        = 28'd1 << 20,
		S_SEMI      = 28'd1 << 21,
		S_SQUOTE    = 28'd1 << 22,
		S_LPAREN    = 28'd1 << 23,
		S_RPAREN    = 28'd1 << 24,
		S_LBRACE    = 28'd1 << 25,
		S_RBRACE    = 28'd1 << 26,
		S_DOLLAR    = 28'd1 << 27
	} dfa_state_t;

	typedef struct packed {
		dfa_state_t         state;
		logic               err;
		logic               kw_hit;
		logic [CLASS_W-1:0] kw_code;
	} tok_word_t;

	localparam logic [63:0] KW_TEXT [NUM_KW] = '{
		"int", "float", "void", "if", "while", "return", "else", "for",
		"auto", "break", "case", "char", "const", "continue", "default", "do",
		"enum", "extern", "goto", "long", "register", "short", "signed",
		"sizeof", "static", "struct", "switch", "typedef", "union",
		"unsigned", "volatile"
	};

	localparam logic [3:0] KW_LEN [NUM_KW] = '{
		4'd3, 4'd5, 4'd4, 4'd2, 4'd5, 4'd6, 4'd4, 4'd3, 4'd4, 4'd5, 4'd4,
		4'd4, 4'd5, 4'd8, 4'd7, 4'd2, 4'd4, 4'd6, 4'd4, 4'd4, 4'd8, 4'd5,
		4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd7, 4'd5, 4'd8, 4'd8
	};

	localparam logic [CLASS_W-1:0] KW_CODE [NUM_KW] = '{
		6'd4, 6'd4, 6'd4, 6'd19, 6'd20, 6'd21, 6'd22, 6'd24, 6'd25, 6'd26,
		6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35,
		6'd36, 6'd37, 6'd38, 6'd39, 6'd40, 6'd41, 6'd42, 6'd43, 6'd44,
		6'd45, 6'd46, 6'd48
	};

	// Keyword text is right-aligned in each entry, so the first character sits highest.
	function automatic logic [7:0] kw_char(input int k, input logic [3:0] pos);
		logic [3:0] sh;
		sh = KW_LEN[k] - 4'd1 - pos;
		return 8'(KW_TEXT[k] >> {sh, 3'b000});
	endfunction

endpackage

// ===== rtl/core/cltc_front.sv =====
// Front end: runs each character through the DFA and the keyword match bank.
module cltc_front #(
	parameter int MAX_KEYWORD_LEN = cltc_pkg::DEF_MAX_KW_LEN
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                q_full,
	input  logic [7:0]          line_char,
	input  logic                line_end,
	output logic                in_stall,
	output logic                push,
	output cltc_pkg::tok_word_t push_word
);

	cltc_pkg::dfa_state_t             state_q, state_n, nxt;
	logic                             err_q, err_n, nxt_ok;
	logic [cltc_pkg::NUM_KW-1:0]      cand_q, cand_n;
	logic [3:0]                       pos_q, pos_n;
	logic                             open_q, open_n;
	logic                             accept, is_space, is_lower, is_digit, finish;
	logic                             kw_hit;
	logic [cltc_pkg::CLASS_W-1:0]     kw_code;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign is_space = (line_char == cltc_pkg::CH_SPACE);
	assign is_lower = line_char inside {[8'h61:8'h7a]};
	assign is_digit = line_char inside {[8'h30:8'h39]};

	always_comb begin
		nxt    = state_q;
		nxt_ok = 1'b1;
		case (state_q)
			cltc_pkg::S_START: begin
				if (is_lower) nxt = cltc_pkg::S_IDENT;
				else if (is_digit) nxt = cltc_pkg::S_INT;
				else if (line_char == cltc_pkg::CH_DQUOTE) nxt = cltc_pkg::S_STR_OPEN;
				else if (line_char inside {8'h2b, 8'h2d}) nxt = cltc_pkg::S_ADD;
				else if (line_char inside {8'h2a, 8'h2f}) nxt = cltc_pkg::S_MUL;
				else if (line_char inside {8'h3c, 8'h3e}) nxt = cltc_pkg::S_REL;
				else if (line_char == 8'h7c) nxt = cltc_pkg::S_BAR;
				else if (line_char == 8'h26) nxt = cltc_pkg::S_AMP;
				else if (line_char == 8'h21) nxt = cltc_pkg::S_NOT;
				else if (line_char == 8'h3d) nxt = cltc_pkg::S_ASSIGN;
				else if (line_char == 8'h3b) nxt = cltc_pkg::S_SEMI;
				else if (line_char == cltc_pkg::CH_SQUOTE) nxt = cltc_pkg::S_SQUOTE;
				else if (line_char == 8'h28) nxt = cltc_pkg::S_LPAREN;
				else if (line_char == 8'h29) nxt = cltc_pkg::S_RPAREN;
				else if (line_char == 8'h7b) nxt = cltc_pkg::S_LBRACE;
				else if (line_char == 8'h7d) nxt = cltc_pkg::S_RBRACE;
				else if (line_char == cltc_pkg::CH_DOLLAR) nxt = cltc_pkg::S_DOLLAR;
				else nxt_ok = 1'b0;
			end
			cltc_pkg::S_IDENT: begin
				nxt_ok = is_lower || is_digit;
			end
			cltc_pkg::S_INT: begin
				if (line_char == 8'h2e) nxt = cltc_pkg::S_DOT;
				else nxt_ok = is_digit;
			end
			cltc_pkg::S_DOT, cltc_pkg::S_REAL: begin
				nxt    = cltc_pkg::S_REAL;
				nxt_ok = is_digit;
			end
			cltc_pkg::S_STR_OPEN, cltc_pkg::S_STR_BODY: begin
				if (line_char == cltc_pkg::CH_DQUOTE) begin
					nxt = (state_q == cltc_pkg::S_STR_OPEN) ? cltc_pkg::S_STR_EMPTY
						: cltc_pkg::S_STR_DONE;
				end else begin
					nxt    = cltc_pkg::S_STR_BODY;
					nxt_ok = is_lower || is_digit;
				end
			end
			cltc_pkg::S_REL: begin
				nxt    = cltc_pkg::S_REL_EQ;
				nxt_ok = (line_char == 8'h3d);
			end
			cltc_pkg::S_BAR: begin
				nxt    = cltc_pkg::S_OR;
				nxt_ok = (line_char == 8'h7c);
			end
			cltc_pkg::S_AMP: begin
				nxt    = cltc_pkg::S_AND;
				nxt_ok = (line_char == 8'h26);
			end
			cltc_pkg::S_NOT: begin
				nxt    = cltc_pkg::S_NE;
				nxt_ok = (line_char == 8'h3d);
			end
			cltc_pkg::S_ASSIGN: begin
				nxt    = cltc_pkg::S_EQ;
				nxt_ok = (line_char == 8'h3d);
			end
			default: begin
				nxt_ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_n = state_q;
		err_n   = err_q;
		cand_n  = cand_q;
		pos_n   = pos_q;
		open_n  = open_q;
		if (!is_space) begin
			open_n = 1'b1;
			for (int k = 0; k < cltc_pkg::NUM_KW; k++) begin
				cand_n[k] = cand_q[k]
					&& (cltc_pkg::KW_LEN[k] <= 4'(MAX_KEYWORD_LEN))
					&& (pos_q < cltc_pkg::KW_LEN[k])
					&& (cltc_pkg::kw_char(k, pos_q) == line_char);
			end
			if (pos_q != 4'hf) pos_n = pos_q + 4'd1;
			if (!err_q) begin
				if (nxt_ok) state_n = nxt;
				else err_n = 1'b1;
			end
		end
	end

	always_comb begin
		kw_hit  = 1'b0;
		kw_code = cltc_pkg::CL_IDENT;
		for (int k = cltc_pkg::NUM_KW - 1; k >= 0; k--) begin
			if (cand_n[k] && (cltc_pkg::KW_LEN[k] == pos_n)) begin
				kw_hit  = 1'b1;
				kw_code = cltc_pkg::KW_CODE[k];
			end
		end
	end

	assign finish = (is_space || line_end) && open_n;
	assign push   = accept && finish;

	assign push_word.state   = state_n;
	assign push_word.err     = err_n;
	assign push_word.kw_hit  = kw_hit;
	assign push_word.kw_code = kw_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cltc_pkg::S_START;
			err_q   <= 1'b0;
			cand_q  <= '1;
			pos_q   <= '0;
			open_q  <= 1'b0;
		end else if (accept) begin
			if (finish || line_end) begin
				state_q <= cltc_pkg::S_START;
				err_q   <= 1'b0;
				cand_q  <= '1;
				pos_q   <= '0;
				open_q  <= 1'b0;
			end else begin
				state_q <= state_n;
				err_q   <= err_n;
				cand_q  <= cand_n;
				pos_q   <= pos_n;
				open_q  <= open_n;
			end
		end
	end

endmodule

// ===== rtl/core/cltc_queue.sv =====
// Small register queue of finished token words between the front and back ends.
module cltc_queue #(
	parameter int DEPTH = cltc_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  cltc_pkg::tok_word_t push_word,
	input  logic                pop,
	output logic                full,
	output logic                empty,
	output cltc_pkg::tok_word_t head_word
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	cltc_pkg::tok_word_t mem_q [DEPTH];
	logic [PW-1:0]       wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]       count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign head_word = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== rtl/core/cltc_back.sv =====
// Back end: resolves the token class from the final DFA state and drives the output word.
module cltc_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_empty,
	input  cltc_pkg::tok_word_t                 head_word,
	input  logic                                out_stall,
	output logic                                pop,
	output logic                                out_valid,
	output logic [cltc_pkg::CLASS_W-1:0]        token_class,
	output logic                                token_invalid
);

	logic                         valid_q, inv_q, bad;
	logic [cltc_pkg::CLASS_W-1:0] class_q, cls;

	always_comb begin
		cls = cltc_pkg::CL_IDENT;
		bad = 1'b0;
		case (head_word.state)
			cltc_pkg::S_IDENT:     cls = head_word.kw_hit ? head_word.kw_code
				: cltc_pkg::CL_IDENT;
			cltc_pkg::S_INT:       cls = cltc_pkg::CL_INT;
			cltc_pkg::S_REAL:      cls = cltc_pkg::CL_REAL;
			cltc_pkg::S_STR_EMPTY,
			cltc_pkg::S_STR_DONE:  cls = cltc_pkg::CL_STRING;
			cltc_pkg::S_ADD:       cls = cltc_pkg::CL_ADD;
			cltc_pkg::S_MUL:       cls = cltc_pkg::CL_MUL;
			cltc_pkg::S_REL,
			cltc_pkg::S_REL_EQ:    cls = cltc_pkg::CL_REL;
			cltc_pkg::S_OR:        cls = cltc_pkg::CL_OR;
			cltc_pkg::S_AND:       cls = cltc_pkg::CL_AND;
			cltc_pkg::S_NOT:       cls = cltc_pkg::CL_NOT;
			cltc_pkg::S_NE,
			cltc_pkg::S_EQ:        cls = cltc_pkg::CL_EQNE;
			cltc_pkg::S_ASSIGN:    cls = cltc_pkg::CL_ASSIGN;
			cltc_pkg::S_SEMI:      cls = cltc_pkg::CL_SEMI;
			cltc_pkg::S_SQUOTE:    cls = cltc_pkg::CL_SQUOTE;
			cltc_pkg::S_LPAREN:    cls = cltc_pkg::CL_LPAREN;
			cltc_pkg::S_RPAREN:    cls = cltc_pkg::CL_RPAREN;
			cltc_pkg::S_LBRACE:    cls = cltc_pkg::CL_LBRACE;
			cltc_pkg::S_RBRACE:    cls = cltc_pkg::CL_RBRACE;
			cltc_pkg::S_DOLLAR:    cls = cltc_pkg::CL_DOLLAR;
			default:               bad = 1'b1;
		endcase
		if (head_word.err) bad = 1'b1;
		if (bad) cls = cltc_pkg::CL_IDENT;
	end

	assign pop           = !q_empty && (!valid_q || !out_stall);
	assign out_valid     = valid_q;
	assign token_class   = class_q;
	assign token_invalid = inv_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			class_q <= cls;
			inv_q   <= bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/core/c_like_token_classifier_unit.sv =====
// Top level of the token classifier: front end, word queue and back end.
// The block takes one character per cycle and stalls its input only when the word queue
// of QUEUE_DEPTH finished tokens is full. A token ends at a space or at the last character
// of a line; its class word goes through the queue and then the output register, which it
// reaches once the queue is drained to it, and stays there until taken. The front end's
// combinational DFA and keyword match bank set the one-cycle-per-character rate.
module c_like_token_classifier_unit #(
	parameter int MAX_KEYWORD_LEN = cltc_pkg::DEF_MAX_KW_LEN,
	parameter int QUEUE_DEPTH     = cltc_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [7:0]                   line_char,
	input  logic                         line_end,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [cltc_pkg::CLASS_W-1:0] token_class,
	output logic                         token_invalid
);

	logic                q_full, q_empty, push, pop;
	cltc_pkg::tok_word_t push_word, head_word;

	cltc_front #(
		.MAX_KEYWORD_LEN(MAX_KEYWORD_LEN)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.q_full    (q_full),
		.line_char (line_char),
		.line_end  (line_end),
		.in_stall  (in_stall),
		.push      (push),
		.push_word (push_word)
	);

	cltc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.full      (q_full),
		.empty     (q_empty),
		.head_word (head_word)
	);

	cltc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.head_word     (head_word),
		.out_stall     (out_stall),
		.pop           (pop),
		.out_valid     (out_valid),
		.token_class   (token_class),
		.token_invalid (token_invalid)
	);

endmodule

// ===== rtl/core/cltc_checker.sv =====
// Port-level checks of the token classifier, bound to its top level.
module cltc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [5:0] token_class,
	input logic       token_invalid
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(token_class) && $stable(token_invalid))
		else $error("output word changed while stalled");

	a_invalid_class: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_invalid |-> token_class == cltc_pkg::CL_IDENT)
		else $error("invalid token carries a nonzero class");

	a_class_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !token_invalid |-> token_class <= 6'd46 || token_class == 6'd48)
		else $error("token class outside the defined codes");

	a_word_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("output word appeared without a preceding input word");

endmodule

bind c_like_token_classifier_unit cltc_checker u_cltc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.token_class   (token_class),
	.token_invalid (token_invalid)
);
